// File: src/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared types and function codes of the SPECIAL group execute block.
// ----------------------------------------------------------------------------
package mse_pkg;

    localparam logic [5:0] FN_SLL    = 6'h00;
    localparam logic [5:0] FN_SRL    = 6'h02;
    localparam logic [5:0] FN_SRA    = 6'h03;
    localparam logic [5:0] FN_SLLV   = 6'h04;
    localparam logic [5:0] FN_SRLV   = 6'h06;
    localparam logic [5:0] FN_SRAV   = 6'h07;
    localparam logic [5:0] FN_JR     = 6'h08;
    localparam logic [5:0] FN_JALR   = 6'h09;
    localparam logic [5:0] FN_MOVZ   = 6'h0A;
    localparam logic [5:0] FN_MOVN   = 6'h0B;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_MFHI   = 6'h10;
    localparam logic [5:0] FN_MTHI   = 6'h11;
    localparam logic [5:0] FN_MFLO   = 6'h12;
    localparam logic [5:0] FN_MTLO   = 6'h13;
    localparam logic [5:0] FN_DSLLV  = 6'h14;
    localparam logic [5:0] FN_DSRLV  = 6'h16;
    localparam logic [5:0] FN_DSRAV  = 6'h17;
    localparam logic [5:0] FN_MULT   = 6'h18;
    localparam logic [5:0] FN_MULTU  = 6'h19;
    localparam logic [5:0] FN_DIV    = 6'h1A;
    localparam logic [5:0] FN_DIVU   = 6'h1B;
    localparam logic [5:0] FN_ADD    = 6'h20;
    localparam logic [5:0] FN_ADDU   = 6'h21;
    localparam logic [5:0] FN_SUB    = 6'h22;
    localparam logic [5:0] FN_SUBU   = 6'h23;
    localparam logic [5:0] FN_AND    = 6'h24;
    localparam logic [5:0] FN_OR     = 6'h25;
    localparam logic [5:0] FN_XOR    = 6'h26;
    localparam logic [5:0] FN_NOR    = 6'h27;
    localparam logic [5:0] FN_MFSA   = 6'h28;
    localparam logic [5:0] FN_MTSA   = 6'h29;
    localparam logic [5:0] FN_SLT    = 6'h2A;
    localparam logic [5:0] FN_SLTU   = 6'h2B;
    localparam logic [5:0] FN_DADD   = 6'h2C;
    localparam logic [5:0] FN_DADDU  = 6'h2D;
    localparam logic [5:0] FN_DSUB   = 6'h2E;
    localparam logic [5:0] FN_DSUBU  = 6'h2F;
    localparam logic [5:0] FN_DSLL   = 6'h38;
    localparam logic [5:0] FN_DSRL   = 6'h3A;
    localparam logic [5:0] FN_DSRA   = 6'h3B;
    localparam logic [5:0] FN_DSLL32 = 6'h3C;
    localparam logic [5:0] FN_DSRL32 = 6'h3E;
    localparam logic [5:0] FN_DSRA32 = 6'h3F;

    localparam int DivSteps = 32;

    typedef struct packed {
        logic        cmd;
        logic [31:0] instruction;
        logic [31:0] delay_slot_pc;
        logic [4:0]  load_index;
        logic [63:0] load_value;
    } in_word_t;

    typedef struct packed {
        logic        write_enable;
        logic [4:0]  write_index;
        logic [63:0] write_value;
        logic [63:0] hi_value;
        logic [63:0] lo_value;
        logic [63:0] shift_amount_value;
        logic        jump_taken;
        logic [31:0] jump_target;
        logic        syscall_request;
    } out_word_t;

    typedef struct packed {
        logic capture;
        logic read_ops;
        logic execute;
        logic mul_step;
        logic div_start;
        logic div_step;
    } dp_cmd_t;

    typedef struct packed {
        logic is_mul;
        logic is_div;
        logic div_last;
    } dp_status_t;

endpackage

// File: src/mse_if.sv
// ----------------------------------------------------------------------------
// mse_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface mse_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: src/mse_ctrl.sv
// ----------------------------------------------------------------------------
// mse_ctrl
// Sequencer: takes a word, reads operands, executes or iterates, then
// presents the result word until it is taken.
// ----------------------------------------------------------------------------
module mse_ctrl
    import mse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV,
        S_EXEC,
        S_OUT
    } state_t;

    state_t state_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        cmd = '0;
        cmd.capture = in_valid && in_ready;
        unique case (state_reg)
            S_READ:
            begin
                cmd.read_ops  = 1'b1;
                cmd.div_start = status.is_div;
            end
            S_MUL:   cmd.mul_step = 1'b1;
            S_DIV:   cmd.div_step = 1'b1;
            S_EXEC:  cmd.execute  = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE: if (in_valid) state_reg <= S_READ;
                S_READ:
                begin
                    priority if (status.is_mul) state_reg <= S_MUL;
                    else if (status.is_div)     state_reg <= S_DIV;
                    else                        state_reg <= S_EXEC;
                end
                S_MUL: state_reg <= S_EXEC;
                S_DIV: if (status.div_last) state_reg <= S_EXEC;
                S_EXEC: state_reg <= S_OUT;
                S_OUT: if (out_ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: src/mse_datapath.sv
// ----------------------------------------------------------------------------
// mse_datapath
// Register file, HI/LO/SA, shifter, adder, multiplier and a radix-2
// divider, driven by the sequencer.
// ----------------------------------------------------------------------------
module mse_datapath
    import mse_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  in_word_t   in_word,
    input  dp_cmd_t    cmd,
    output dp_status_t status,
    output out_word_t  out_word
);

    localparam int DivCountW = $clog2(DivSteps + 1);

    logic [63:0] regs_mem [32];
    logic [31:0] valid_reg;
    in_word_t    in_reg;
    logic [63:0] vs_reg;
    logic [63:0] vt_reg;
    logic [63:0] hi_reg;
    logic [63:0] lo_reg;
    logic [63:0] sa_reg;
    logic [63:0] prod_reg;
    logic [31:0] quo_reg;
    logic [32:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [DivCountW-1:0] dcnt_reg;
    logic        qneg_reg;
    logic        rneg_reg;
    logic        dzero_reg;
    out_word_t   out_reg;

    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;

    assign fn = in_reg.instruction[5:0];
    assign rs = in_reg.instruction[25:21];
    assign rt = in_reg.instruction[20:16];
    assign rd = in_reg.instruction[15:11];
    assign sa = in_reg.instruction[10:6];

    assign status.is_mul   = !in_reg.cmd && (fn == FN_MULT || fn == FN_MULTU);
    assign status.is_div   = !in_reg.cmd && (fn == FN_DIV || fn == FN_DIVU);
    assign status.div_last = (dcnt_reg == DivCountW'(DivSteps));
    assign out_word        = out_reg;

    function automatic logic [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    logic        sgn;
    logic [31:0] abs_a;
    logic [31:0] abs_b;
    logic [32:0] rem_shift;
    logic [32:0] rem_sub;
    logic [63:0] sh_in;
    logic [5:0]  sh_amt;
    logic [63:0] sh_left;
    logic [63:0] sh_right;
    logic [63:0] sh_arith;
    logic [63:0] add64;
    logic [63:0] sub64;
    logic [63:0] prod_fix;
    logic [31:0] q_fix;
    logic [31:0] r_fix;
    logic        wr;
    logic [63:0] wval;
    logic [63:0] hi_n;
    logic [63:0] lo_n;
    logic [63:0] sa_n;

    always_comb
    begin
        sgn   = (fn == FN_MULT) || (fn == FN_DIV);
        abs_a = (sgn && vs_reg[31]) ? 32'(-vs_reg[31:0]) : vs_reg[31:0];
        abs_b = (sgn && vt_reg[31]) ? 32'(-vt_reg[31:0]) : vt_reg[31:0];
        rem_shift = {rem_reg[31:0], quo_reg[31]};
        rem_sub   = rem_shift - {1'b0, dvs_reg};
    end

    always_comb
    begin
        sh_in  = vt_reg;
        sh_amt = vs_reg[5:0];
        unique case (fn)
            FN_SLL, FN_SRL:   begin sh_in = {32'd0, vt_reg[31:0]}; sh_amt = {1'b0, sa}; end
            FN_SRA:           begin sh_in = sx32(vt_reg[31:0]); sh_amt = {1'b0, sa}; end
            FN_SLLV, FN_SRLV: begin sh_in = {32'd0, vt_reg[31:0]}; sh_amt = {1'b0, vs_reg[4:0]}; end
            FN_SRAV:          begin sh_in = sx32(vt_reg[31:0]); sh_amt = {1'b0, vs_reg[4:0]}; end
            FN_DSLL, FN_DSRL, FN_DSRA:       sh_amt = {1'b0, sa};
            FN_DSLL32, FN_DSRL32, FN_DSRA32: sh_amt = {1'b1, sa};
            default: ;
        endcase
        sh_left  = sh_in << sh_amt;
        sh_right = sh_in >> sh_amt;
        sh_arith = 64'($signed(sh_in) >>> sh_amt);
        add64    = vs_reg + vt_reg;
        sub64    = vs_reg - vt_reg;
        prod_fix = qneg_reg ? 64'(-prod_reg) : prod_reg;
        q_fix    = qneg_reg ? 32'(-quo_reg) : quo_reg;
        r_fix    = rneg_reg ? 32'(-rem_reg[31:0]) : rem_reg[31:0];
    end

    always_comb
    begin
        wr   = 1'b0;
        wval = '0;
        hi_n = hi_reg;
        lo_n = lo_reg;
        sa_n = sa_reg;
        if (in_reg.cmd)
        begin
            wr   = 1'b1;
            wval = in_reg.load_value;
        end
        else
        begin
            unique case (fn)
                FN_SLL, FN_SLLV:     begin wval = sx32(sh_left[31:0]); wr = 1'b1; end
                FN_SRL, FN_SRLV:     begin wval = sh_right; wr = 1'b1; end
                FN_SRA, FN_SRAV, FN_DSRAV, FN_DSRA, FN_DSRA32:
                                     begin wval = sh_arith; wr = 1'b1; end
                FN_DSLLV, FN_DSLL, FN_DSLL32: begin wval = sh_left; wr = 1'b1; end
                FN_DSRLV, FN_DSRL, FN_DSRL32: begin wval = sh_right; wr = 1'b1; end
                FN_JALR:   begin wval = {32'd0, 32'(in_reg.delay_slot_pc + 32'd4)}; wr = 1'b1; end
                FN_MOVZ:   begin wval = vs_reg; wr = (vt_reg == 64'd0); end
                FN_MOVN:   begin wval = vs_reg; wr = (vt_reg != 64'd0); end
                FN_MFHI:   begin wval = hi_reg; wr = 1'b1; end
                FN_MTHI:   hi_n = vs_reg;
                FN_MFLO:   begin wval = lo_reg; wr = 1'b1; end
                FN_MTLO:   lo_n = vs_reg;
                FN_MULT, FN_MULTU:
                begin
                    lo_n = sx32(prod_fix[31:0]);
                    hi_n = sx32(prod_fix[63:32]);
                    wval = lo_n;
                    wr   = 1'b1;
                end
                FN_DIV, FN_DIVU:
                begin
                    if (!dzero_reg)
                    begin
                        lo_n = sx32(q_fix);
                        hi_n = sx32(r_fix);
                    end
                end
                FN_ADD, FN_ADDU:   begin wval = sx32(add64[31:0]); wr = 1'b1; end
                FN_SUB, FN_SUBU:   begin wval = sx32(sub64[31:0]); wr = 1'b1; end
                FN_AND:    begin wval = vs_reg & vt_reg; wr = 1'b1; end
                FN_OR:     begin wval = vs_reg | vt_reg; wr = 1'b1; end
                FN_XOR:    begin wval = vs_reg ^ vt_reg; wr = 1'b1; end
                FN_NOR:    begin wval = ~(vs_reg | vt_reg); wr = 1'b1; end
                FN_MFSA:   begin wval = sa_reg; wr = 1'b1; end
                FN_MTSA:   sa_n = vs_reg;
                FN_SLT:    begin wval = {63'd0, $signed(vs_reg) < $signed(vt_reg)}; wr = 1'b1; end
                FN_SLTU:   begin wval = {63'd0, vs_reg < vt_reg}; wr = 1'b1; end
                FN_DADD, FN_DADDU: begin wval = add64; wr = 1'b1; end
                FN_DSUB, FN_DSUBU: begin wval = sub64; wr = 1'b1; end
                default: ;
            endcase
        end
    end

    logic [4:0] widx;
    logic       wen;
    assign widx = in_reg.cmd ? in_reg.load_index : rd;
    assign wen  = wr && (widx != 5'd0);

    logic [32:0] rem_next;
    logic [31:0] quo_next;
    always_comb
    begin
        rem_next = rem_sub[32] ? rem_shift : rem_sub;
        quo_next = {quo_reg[30:0], ~rem_sub[32]};
    end

    // The divider runs one setup step and then one restoring step per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            in_reg <= in_word;
        if (cmd.read_ops)
        begin
            vs_reg <= (rs != 5'd0 && valid_reg[rs]) ? regs_mem[rs] : 64'd0;
            vt_reg <= (rt != 5'd0 && valid_reg[rt]) ? regs_mem[rt] : 64'd0;
        end
        if (cmd.mul_step)
        begin
            prod_reg <= abs_a * abs_b;
            qneg_reg <= sgn && (vs_reg[31] ^ vt_reg[31]);
        end
        if (cmd.div_start)
        begin
            dcnt_reg <= '0;
        end
        if (cmd.div_step)
        begin
            if (dcnt_reg == '0)
            begin
                quo_reg   <= abs_a;
                rem_reg   <= '0;
                dvs_reg   <= abs_b;
                qneg_reg  <= sgn && (vs_reg[31] ^ vt_reg[31]);
                rneg_reg  <= sgn && vs_reg[31];
                dzero_reg <= (vt_reg[31:0] == 32'd0);
            end
            else
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
            end
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.execute && wen)
            regs_mem[widx] <= wval;
        if (cmd.execute)
        begin
            out_reg.write_enable       <= wen;
            out_reg.write_index        <= wen ? widx : 5'd0;
            out_reg.write_value        <= wen ? wval : 64'd0;
            out_reg.hi_value           <= hi_n;
            out_reg.lo_value           <= lo_n;
            out_reg.shift_amount_value <= sa_n;
            out_reg.jump_taken         <= !in_reg.cmd && (fn == FN_JR || fn == FN_JALR);
            out_reg.jump_target        <= (!in_reg.cmd && (fn == FN_JR || fn == FN_JALR))
                                          ? vs_reg[31:0] : 32'd0;
            out_reg.syscall_request    <= !in_reg.cmd && (fn == FN_SYSCALL);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hi_reg    <= '0;
            lo_reg    <= '0;
            sa_reg    <= '0;
        end
        else if (cmd.execute)
        begin
            if (wen)
                valid_reg[widx] <= 1'b1;
            hi_reg <= hi_n;
            lo_reg <= lo_n;
            sa_reg <= sa_n;
        end
    end

endmodule

// File: src/mips64_special_group_execute_top.sv
// ----------------------------------------------------------------------------
// mips64_special_group_execute_top
// SPECIAL opcode group execute unit with register file, HI, LO and SA.
// ----------------------------------------------------------------------------
// Channel  Direction  Word
// in       sink       cmd, instruction, delay_slot_pc, load_index, load_value
// out      source     write and HI/LO/SA state, jump and syscall flags
//
// Most words pass from acceptance to result through capture, operand
// read, execute and output. Mult adds a multiplier step; div/divu add
// the setup and restoring steps of the bit-serial divider. One word is
// in flight at a time, and a stalled result holds the block. Reset clears
// the register file valid bits and HI, LO and SA at once.
// ----------------------------------------------------------------------------
module mips64_special_group_execute_top
    import mse_pkg::*;
(
    input logic clk,
    input logic rst_n,
    mse_if.sink   in,
    mse_if.source out
);

    dp_cmd_t    cmd;
    dp_status_t status;
    out_word_t  result;

    mse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_ready  (in.ready),
        .out_valid (out.valid),
        .out_ready (out.ready),
        .status    (status),
        .cmd       (cmd)
    );

    mse_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_word  (in.payload),
        .cmd      (cmd),
        .status   (status),
        .out_word (result)
    );

    assign out.payload = result;

endmodule
